### src/mzrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mzrd_pkg
// Shared constants, types and state codes for the move-to-front decoder
// with zero-run expansion.
// ----------------------------------------------------------------------------
package mzrd_pkg;

    // Alphabet and field widths
    localparam int ALPHABET_SIZE = 256;
    localparam int SYM_W         = 8;
    localparam int CNT_W         = 9;
    localparam int POS_W         = $clog2(ALPHABET_SIZE);

    // Symbol select tree: groups of cells reduced in the first registered level
    localparam int GROUP_SIZE    = 16;
    localparam int NUM_GROUPS    = (ALPHABET_SIZE + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_SIZE      = NUM_GROUPS * GROUP_SIZE;

    // Highest table position, as a code byte
    localparam logic [SYM_W-1:0] LAST_CODE = SYM_W'(ALPHABET_SIZE - 1);
    localparam logic [SYM_W-1:0] RUN_MARK  = '0;

    typedef logic [SYM_W-1:0] sym_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_FINISH
    } state_t;

    // Control broadcast to every cell of the table
    typedef struct packed {
        logic load_identity;
        logic shift;
        pos_t pos;
        sym_t front;
    } cell_ctrl_t;

endpackage

### src/mzrd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mzrd_in_if
// Code byte channel: valid/ready handshake with code byte and restart flag.
// ----------------------------------------------------------------------------
interface mzrd_in_if;

    logic          valid;
    logic          ready;
    mzrd_pkg::sym_t code_byte;
    logic          restart;

    modport source (output valid, output code_byte, output restart, input ready);
    modport sink   (input valid, input code_byte, input restart, output ready);

endinterface

### src/mzrd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mzrd_out_if
// Decoded symbol channel: valid/ready handshake with symbol and repeat count.
// ----------------------------------------------------------------------------
interface mzrd_out_if;

    logic           valid;
    logic           ready;
    mzrd_pkg::sym_t symbol;
    mzrd_pkg::cnt_t repeat_count;

    modport source (output valid, output symbol, output repeat_count, input ready);
    modport sink   (input valid, input symbol, input repeat_count, output ready);

endinterface

### src/mzrd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mzrd_cell
// One entry of the move-to-front table. On a shift at or below the selected
// position it takes its lower neighbor's value (entry zero: the front symbol).
// ----------------------------------------------------------------------------
module mzrd_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mzrd_pkg::pos_t       idx,
    input  mzrd_pkg::cell_ctrl_t ctrl,
    input  mzrd_pkg::sym_t       prev_value,
    output mzrd_pkg::sym_t       value,
    output mzrd_pkg::sym_t       masked
);

    mzrd_pkg::sym_t value_reg;
    mzrd_pkg::sym_t value_next;
    logic           in_range;
    logic           hit;

    assign in_range = (idx <= ctrl.pos);
    assign hit      = (idx == ctrl.pos);

    // Pick the next entry value: identity on restart, shift or front load on move
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load_identity)
        begin
            value_next = mzrd_pkg::SYM_W'(idx);
        end
        else if (ctrl.shift && in_range)
        begin
            if (idx == '0)
            begin
                value_next = ctrl.front;
            end
            else
            begin
                value_next = prev_value;
            end
        end
    end

    // Hold the entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= mzrd_pkg::SYM_W'(idx);
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value  = value_reg;
    assign masked = hit ? value_reg : '0;

endmodule

### src/mzrd_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mzrd_select
// Registered OR tree that collects the one masked cell value that matches
// the selected position. First level per group is registered; the final
// level combines the group results.
// ----------------------------------------------------------------------------
module mzrd_select
(
    input  logic           clk,
    input  mzrd_pkg::sym_t masked [mzrd_pkg::PAD_SIZE],
    output mzrd_pkg::sym_t selected
);

    mzrd_pkg::sym_t part_reg  [mzrd_pkg::NUM_GROUPS];
    mzrd_pkg::sym_t part_next [mzrd_pkg::NUM_GROUPS];

    // Reduce each group of cells
    always_comb
    begin
        for (int g = 0; g < mzrd_pkg::NUM_GROUPS; g++)
        begin
            part_next[g] = '0;
            for (int j = 0; j < mzrd_pkg::GROUP_SIZE; j++)
            begin
                part_next[g] = part_next[g] | masked[g * mzrd_pkg::GROUP_SIZE + j];
            end
        end
    end

    // Hold group results
    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
    end

    // Combine group results
    always_comb
    begin
        selected = '0;
        for (int g = 0; g < mzrd_pkg::NUM_GROUPS; g++)
        begin
            selected = selected | part_reg[g];
        end
    end

endmodule

### src/mtf_zero_run_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_zero_run_decoder_unit
// Move-to-front decoder with zero-run expansion over a row of table cells.
// ----------------------------------------------------------------------------
// One code byte is taken per transfer. A run marker (zero code) gives no
// result. A run length goes to the finish state and gives the front symbol
// with a count of byte plus one. A table position goes through the gather
// and finish states: the matching cell value passes a two-level select tree
// over the cell row, whose first level is registered in gather, then in
// finish all cells at or below the position shift together and the symbol
// lands at the front. The input is ready again as soon as the result is in
// the output register, so one finished result may wait while the next byte
// enters; a result that still waits when the next one is finished holds the
// block. Reset sets the table to identity order at once.
// ----------------------------------------------------------------------------
module mtf_zero_run_decoder_unit
(
    input  logic       clk,
    input  logic       rst_n,
    mzrd_in_if.sink    data_in,
    mzrd_out_if.source data_out
);

    mzrd_pkg::state_t     state_reg;
    mzrd_pkg::state_t     state_next;
    mzrd_pkg::cell_ctrl_t ctrl;

    mzrd_pkg::sym_t values [mzrd_pkg::ALPHABET_SIZE];
    mzrd_pkg::sym_t masked [mzrd_pkg::PAD_SIZE];
    mzrd_pkg::sym_t sym_sel;

    logic           run_pending_reg;
    logic           run_pending_next;
    logic           is_run_reg;
    mzrd_pkg::sym_t code_reg;
    mzrd_pkg::pos_t pos_reg;
    mzrd_pkg::pos_t pos_in;

    logic           out_valid_reg;
    logic           out_valid_next;
    mzrd_pkg::sym_t symbol_reg;
    mzrd_pkg::cnt_t count_reg;

    logic           accept;
    logic           eff_run;
    logic           is_mark;
    logic           out_free;
    logic           out_load;

    // Handshake and decode of the incoming byte
    assign data_in.ready = (state_reg == mzrd_pkg::ST_IDLE);
    assign accept        = data_in.valid && data_in.ready;
    assign eff_run       = run_pending_reg && !data_in.restart;
    assign is_mark       = (data_in.code_byte == mzrd_pkg::RUN_MARK);
    assign pos_in        = (data_in.code_byte > mzrd_pkg::LAST_CODE)
                         ? mzrd_pkg::POS_W'(mzrd_pkg::LAST_CODE)
                         : mzrd_pkg::POS_W'(data_in.code_byte);
    assign out_free      = !out_valid_reg || data_out.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mzrd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (eff_run)
                    begin
                        state_next = mzrd_pkg::ST_FINISH;
                    end
                    else if (!is_mark)
                    begin
                        state_next = mzrd_pkg::ST_GATHER;
                    end
                end
            end
            mzrd_pkg::ST_GATHER:
            begin
                state_next = mzrd_pkg::ST_FINISH;
            end
            mzrd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = mzrd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mzrd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: cell control and result load
    always_comb
    begin
        out_load           = 1'b0;
        ctrl.load_identity = accept && data_in.restart;
        ctrl.shift         = 1'b0;
        ctrl.pos           = pos_reg;
        ctrl.front         = sym_sel;
        case (state_reg)
            mzrd_pkg::ST_FINISH:
            begin
                out_load   = out_free;
                ctrl.shift = out_free && !is_run_reg;
            end
            default:
            begin
                out_load   = 1'b0;
                ctrl.shift = 1'b0;
            end
        endcase
    end

    // Run flag: cleared by a run length or restart, armed by a marker
    assign run_pending_next = accept ? (!eff_run && is_mark) : run_pending_reg;

    // Output register valid: set on load, drop on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (data_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mzrd_pkg::ST_IDLE;
            run_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            run_pending_reg <= run_pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Capture the accepted byte
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_run_reg <= eff_run;
            code_reg   <= data_in.code_byte;
            pos_reg    <= pos_in;
        end
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (is_run_reg)
            begin
                symbol_reg <= values[0];
                count_reg  <= mzrd_pkg::CNT_W'(code_reg) + mzrd_pkg::CNT_W'(1);
            end
            else
            begin
                symbol_reg <= sym_sel;
                count_reg  <= mzrd_pkg::CNT_W'(1);
            end
        end
    end

    assign data_out.valid        = out_valid_reg;
    assign data_out.symbol       = symbol_reg;
    assign data_out.repeat_count = count_reg;

    // Row of table cells, each fed by its lower neighbor
    for (genvar i = 0; i < mzrd_pkg::ALPHABET_SIZE; i++)
    begin : g_cell
        mzrd_pkg::sym_t prev;
        if (i == 0)
        begin : g_first
            assign prev = '0;
        end
        else
        begin : g_rest
            assign prev = values[i-1];
        end

        mzrd_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (mzrd_pkg::POS_W'(i)),
            .ctrl       (ctrl),
            .prev_value (prev),
            .value      (values[i]),
            .masked     (masked[i])
        );
    end

    // Pad the select tree input
    for (genvar i = mzrd_pkg::ALPHABET_SIZE; i < mzrd_pkg::PAD_SIZE; i++)
    begin : g_pad
        assign masked[i] = '0;
    end

    mzrd_select u_select
    (
        .clk      (clk),
        .masked   (masked),
        .selected (sym_sel)
    );

endmodule

### tb/tb_mtf_zero_run_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mtf_zero_run_decoder_unit
// Self-checking bench for the move-to-front decoder with zero-run expansion.
// ----------------------------------------------------------------------------
// Code bytes go in over the input channel and are decoded in parallel by a
// behavioral move-to-front table kept in the bench. Each decoded symbol and
// repeat count that leaves the block is compared with the oldest pending
// expectation. A directed pass covers the table ends, run markers, run
// lengths of zero and of the maximum, and restarts. It is followed by random
// streams with idle cycles on both sides, a long output stall that backs the
// block up, and a stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_mtf_zero_run_decoder_unit;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 16;
    localparam int IDLE_PCT    = 11;

    typedef struct packed {
        mzrd_pkg::sym_t symbol;
        mzrd_pkg::cnt_t repeat_count;
    } decoded_t;

    logic clk;
    logic rst_n;

    mzrd_in_if  in_if ();
    mzrd_out_if out_if ();

    mtf_zero_run_decoder_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .data_in  (in_if),
        .data_out (out_if)
    );

    // Bench copy of the decoder state
    mzrd_pkg::sym_t mtf_table [mzrd_pkg::ALPHABET_SIZE];
    bit             run_armed;
    decoded_t       pending_symbols [$];

    int  mismatches;
    int  cycle_count;
    bit  steady;
    bit  offering;

    // Output stall request, counted down in the receiver process
    int  hold_len;
    int  hold_req;
    int  hold_ack;
    int  hold_left;

    // Free-running clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Return the table to identity order and clear the run flag
    task automatic table_to_identity();
        for (int i = 0; i < mzrd_pkg::ALPHABET_SIZE; i++)
        begin
            mtf_table[i] = mzrd_pkg::sym_t'(i);
        end
        run_armed = 1'b0;
    endtask

    // Decode one accepted code byte and queue the symbol it yields
    task automatic decode_code(input mzrd_pkg::sym_t code, input logic restart);
        decoded_t       exp_item;
        mzrd_pkg::sym_t pos;
        mzrd_pkg::sym_t sym;
        if (restart)
        begin
            table_to_identity();
        end
        if (run_armed)
        begin
            run_armed = 1'b0;
            exp_item.symbol       = mtf_table[0];
            exp_item.repeat_count = mzrd_pkg::cnt_t'(code) + mzrd_pkg::cnt_t'(1);
            pending_symbols.push_back(exp_item);
        end
        else if (code == mzrd_pkg::RUN_MARK)
        begin
            run_armed = 1'b1;
        end
        else
        begin
            pos = (code > mzrd_pkg::LAST_CODE) ? mzrd_pkg::LAST_CODE : code;
            sym = mtf_table[pos];
            for (int k = int'(pos); k > 0; k--)
            begin
                mtf_table[k] = mtf_table[k-1];
            end
            mtf_table[0] = sym;
            exp_item.symbol       = sym;
            exp_item.repeat_count = mzrd_pkg::cnt_t'(1);
            pending_symbols.push_back(exp_item);
        end
    endtask

    // Offer one code byte and hold it until the transfer
    task automatic send_code(input mzrd_pkg::sym_t code, input logic restart);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            if (offering)
            begin
                in_if.valid <= 1'b0;
                offering = 1'b0;
            end
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.code_byte <= code;
        in_if.restart   <= restart;
        offering = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_if.ready);
        decode_code(code, restart);
    endtask

    // Drop a valid that is offered and wait for the next edge
    task automatic idle_input();
        if (offering)
        begin
            in_if.valid <= 1'b0;
            offering = 1'b0;
            @(posedge clk);
        end
    endtask

    // Hold the sender until every pending symbol has come out
    task automatic wait_drained();
        idle_input();
        while (pending_symbols.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Random code byte, biased toward markers and the front of the table
    task automatic send_random_code();
        int             r;
        mzrd_pkg::sym_t code;
        logic           restart;
        r = $urandom_range(0, 99);
        if (r < 14)
            code = mzrd_pkg::RUN_MARK;
        else if (r < 40)
            code = mzrd_pkg::sym_t'($urandom_range(1, 7));
        else if (r < 65)
            code = mzrd_pkg::sym_t'($urandom_range(1, 31));
        else
            code = mzrd_pkg::sym_t'($urandom_range(0, 255));
        restart = ($urandom_range(0, 99) < 3);
        send_code(code, restart);
    endtask

    task automatic test_directed();
        send_code(8'd1, 1'b0);
        send_code(mzrd_pkg::LAST_CODE, 1'b0);
        // run length of zero gives the front symbol once
        send_code(mzrd_pkg::RUN_MARK, 1'b0);
        send_code(8'd0, 1'b0);
        // longest run
        send_code(mzrd_pkg::RUN_MARK, 1'b0);
        send_code(8'd255, 1'b0);
        // restart drops a pending run
        send_code(mzrd_pkg::RUN_MARK, 1'b0);
        send_code(8'd7, 1'b1);
        // restart together with a marker still arms the run
        send_code(mzrd_pkg::RUN_MARK, 1'b1);
        send_code(8'd128, 1'b0);
        send_code(8'd2, 1'b0);
        send_code(8'd2, 1'b0);
        send_code(8'd1, 1'b0);
        send_code(8'd170, 1'b0);
        send_code(8'd85, 1'b0);
        send_code(mzrd_pkg::RUN_MARK, 1'b0);
        send_code(8'd1, 1'b0);
        send_code(8'd254, 1'b1);
        send_code(mzrd_pkg::LAST_CODE, 1'b0);
        send_code(mzrd_pkg::LAST_CODE, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_stream();
        for (int burst = 0; burst < 15; burst++)
        begin
            for (int i = 0; i < 100; i++)
            begin
                send_random_code();
            end
            if (burst % 4 == 3)
            begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        hold_len = 300;
        hold_req++;
        for (int i = 0; i < 60; i++)
        begin
            send_random_code();
        end
        wait_drained();
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        for (int i = 0; i < 400; i++)
        begin
            send_random_code();
        end
        idle_input();
        steady = 1'b0;
        wait_drained();
    endtask

    // Check each result transfer, then pick the next ready
    always @(posedge clk)
    begin
        decoded_t exp_item;
        if (out_if.valid && out_if.ready)
        begin
            if (pending_symbols.size() == 0)
            begin
                report_mismatch($sformatf("unexpected symbol %0d count %0d",
                                          out_if.symbol, out_if.repeat_count));
            end
            else
            begin
                exp_item = pending_symbols.pop_front();
                if (out_if.symbol !== exp_item.symbol)
                    report_mismatch($sformatf("symbol %0d, expected %0d",
                                              out_if.symbol, exp_item.symbol));
                if (out_if.repeat_count !== exp_item.repeat_count)
                    report_mismatch($sformatf("repeat_count %0d, expected %0d",
                                              out_if.repeat_count,
                                              exp_item.repeat_count));
            end
        end
        if (hold_req != hold_ack)
        begin
            hold_left = hold_len;
            hold_ack  = hold_req;
        end
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_if.ready <= 1'b0;
        end
        else
        begin
            out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("mtf_zero_run_decoder_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_if.valid     = 1'b0;
        in_if.code_byte = '0;
        in_if.restart   = 1'b0;
        out_if.ready    = 1'b0;
        mismatches      = 0;
        cycle_count     = 0;
        steady          = 1'b0;
        offering        = 1'b0;
        hold_len        = 0;
        hold_req        = 0;
        hold_ack        = 0;
        hold_left       = 0;
        table_to_identity();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_stream();
        test_output_backpressure();
        test_steady_stream();

        if (pending_symbols.size() != 0)
        begin
            report_mismatch($sformatf("%0d symbols never came out",
                                      pending_symbols.size()));
        end
        if (mismatches == 0)
        begin
            $display("mtf_zero_run_decoder_unit: match");
        end
        else
        begin
            $display("mtf_zero_run_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
src/mzrd_pkg.sv
src/mzrd_in_if.sv
src/mzrd_out_if.sv
src/mzrd_cell.sv
src/mzrd_select.sv
src/mtf_zero_run_decoder_unit.sv
tb/tb_mtf_zero_run_decoder_unit.sv
